### hdl/dnms_pkg.sv
// shared constants, types and helpers for the directional non-max suppression block
package dnms_pkg;

    // frame geometry and magnitude format
    localparam int MAX_WIDTH  = 1024;
    localparam int MAG_BITS   = 16;
    localparam int ADDR_BITS  = $clog2(MAX_WIDTH);
    localparam int WIDTH_BITS = 11;
    localparam int HEIGHT_BITS = 12;
    localparam int DIR_BITS   = 3;
    localparam int PIX_BITS   = 8;
    localparam int CFG_DATA_BITS = 12;

    // stream payload widths
    localparam int IN_DATA_BITS  = 32;
    localparam int OUT_DATA_BITS = 32;

    // configuration register indexes
    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    // register reset values and clamp limits
    localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = WIDTH_BITS'(640);
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = HEIGHT_BITS'(480);
    localparam logic [WIDTH_BITS-1:0]  WIDTH_MIN    = WIDTH_BITS'(3);
    localparam logic [WIDTH_BITS-1:0]  WIDTH_MAX    = WIDTH_BITS'(MAX_WIDTH);
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_MIN   = HEIGHT_BITS'(3);

    // quantized gradient direction codes
    localparam logic [DIR_BITS-1:0] DIR_0   = 3'd0;
    localparam logic [DIR_BITS-1:0] DIR_45  = 3'd1;
    localparam logic [DIR_BITS-1:0] DIR_90  = 3'd2;
    localparam logic [DIR_BITS-1:0] DIR_135 = 3'd3;

    typedef logic [MAG_BITS-1:0] t_mag;

    // one pixel on its way from the memory read to the decision
    typedef struct packed {
        logic [ADDR_BITS-1:0]   col;
        logic [HEIGHT_BITS-1:0] row;
        t_mag                   mag;
        logic [DIR_BITS-1:0]    dir;
        logic [PIX_BITS-1:0]    pix;
    } t_stage;

    // center magnitude is not below either neighbour along one axis and above at least one of them
    function automatic logic is_peak(input t_mag c, input t_mag a, input t_mag b);
        is_peak = (c >= a) && (c >= b) && ((c > a) || (c > b));
    endfunction

endpackage

### hdl/directional_non_max_suppression.sv
// Directional non-maximum suppression over a 3x3 magnitude window, raster stream in
//
// Takes one pixel per clock in raster order and returns one result per pixel except for
// the first row and the first column of every row; the result for pixel (x, y) leaves when
// pixel (x+1, y+1) has been taken. Each pixel passes a memory read stage (the registered
// read of the two line memories) and a decision stage that writes the memories back, and
// its result is registered in the output queue before it is offered. Input is taken
// at one pixel per clock as long as the three-entry output queue keeps pace with the sink.
// The line memories need no clearing after reset. Width is clamped to 3..1024, height to
// at least 3; register writes belong between frames with the block drained.
module directional_non_max_suppression (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_wr_en,
    input  logic                                i_cfg_index,
    input  logic [dnms_pkg::CFG_DATA_BITS-1:0]  i_cfg_wdata,
    // pixel input
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // gradient_magnitude[15:0], direction[18:16], pixel_value[26:19], zero pad
    input  logic [dnms_pkg::IN_DATA_BITS-1:0]   i_s_tdata,
    // result output
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // column[9:0], row[21:10], pixel_out[29:22], zero pad
    output logic [dnms_pkg::OUT_DATA_BITS-1:0]  o_m_tdata,
    // kept[0]
    output logic                                o_m_tuser
);
    import dnms_pkg::*;

    localparam int CTR_BITS = DIR_BITS + PIX_BITS;
    localparam int RES_BITS = ADDR_BITS + HEIGHT_BITS + PIX_BITS + 1;
    localparam int Q_DEPTH  = 3;

    // configuration registers
    logic [WIDTH_BITS-1:0]  r_width;
    logic [HEIGHT_BITS-1:0] r_height;

    // raster position of the next pixel
    logic [ADDR_BITS-1:0]   r_col, n_col;
    logic [HEIGHT_BITS-1:0] r_row, n_row;

    // line memories: both magnitude lines side by side, and the center row
    logic [2*MAG_BITS-1:0]  mem_mag   [MAX_WIDTH];
    logic [CTR_BITS-1:0]    mem_ctr   [MAX_WIDTH];
    t_mag                   r_prev_rd;
    t_mag                   r_older_rd;
    logic [CTR_BITS-1:0]    r_ctr_rd;

    // decision stage
    logic                   r_s1_valid;
    t_stage                 r_s1;
    t_stage                 n_s1;
    t_mag                   r_win_c1 [3];
    t_mag                   r_win_c2 [3];
    logic [CTR_BITS-1:0]    r_hold;

    // output queue
    logic [RES_BITS-1:0]    r_q [Q_DEPTH];
    logic [1:0]             r_wr_ptr;
    logic [1:0]             r_rd_ptr;
    logic [1:0]             r_q_cnt;

    logic                   in_acc;
    logic                   out_pop;
    logic [WIDTH_BITS-1:0]  w_eff;
    logic [HEIGHT_BITS-1:0] h_eff;
    logic [ADDR_BITS-1:0]   cur_col;
    logic [HEIGHT_BITS-1:0] cur_row;
    logic [HEIGHT_BITS-1:0] wrap_row;
    logic [WIDTH_BITS-1:0]  col_inc;
    logic [HEIGHT_BITS-1:0] row_inc;
    logic [2:0]             occupancy;

    logic                   res_valid;
    logic                   keep;
    logic [DIR_BITS-1:0]    c_dir;
    logic [PIX_BITS-1:0]    c_pix;
    t_mag                   c_mag;
    logic [ADDR_BITS-1:0]   res_col;
    logic [HEIGHT_BITS-1:0] res_row;
    logic [RES_BITS-1:0]    res_word;
    logic [RES_BITS-1:0]    head;

    // handshakes; the queue has room for everything in flight
    assign occupancy  = 3'(r_q_cnt) + 3'(r_s1_valid);
    assign o_s_tready = (occupancy <= 3'd2);
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign out_pop    = o_m_tvalid && i_m_tready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_width  <= i_cfg_wdata[WIDTH_BITS-1:0];
                CFG_IMAGE_HEIGHT: r_height <= i_cfg_wdata[HEIGHT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // clamped frame size
    always_comb begin
        if (r_width < WIDTH_MIN) begin
            w_eff = WIDTH_MIN;
        end else if (r_width > WIDTH_MAX) begin
            w_eff = WIDTH_MAX;
        end else begin
            w_eff = r_width;
        end
        h_eff = (r_height < HEIGHT_MIN) ? HEIGHT_MIN : r_height;
    end

    // position of this pixel, wrapped if the frame shrank, and of the next one
    always_comb begin
        if ({1'b0, r_col} >= w_eff) begin
            cur_col  = '0;
            wrap_row = r_row + 1'b1;
        end else begin
            cur_col  = r_col;
            wrap_row = r_row;
        end
        cur_row = (wrap_row >= h_eff) ? '0 : wrap_row;

        col_inc = {1'b0, cur_col} + 1'b1;
        row_inc = cur_row + 1'b1;
        if (col_inc >= w_eff) begin
            n_col = '0;
            n_row = (row_inc >= h_eff) ? '0 : row_inc;
        end else begin
            n_col = col_inc[ADDR_BITS-1:0];
            n_row = cur_row;
        end

        n_s1.col = cur_col;
        n_s1.row = cur_row;
        n_s1.mag = i_s_tdata[MAG_BITS-1:0];
        n_s1.dir = i_s_tdata[MAG_BITS +: DIR_BITS];
        n_s1.pix = i_s_tdata[MAG_BITS+DIR_BITS +: PIX_BITS];
    end

    // raster counters and stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_acc;
            if (in_acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= n_s1;
        end
    end

    // memory read at the column of the incoming pixel
    always_ff @(posedge i_clk) begin
        {r_older_rd, r_prev_rd} <= mem_mag[cur_col];
        r_ctr_rd                <= mem_ctr[cur_col];
    end

    // memory write back in the cycle after the read; a column recurs only after three pixels
    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            mem_mag[r_s1.col] <= {r_prev_rd, r_s1.mag};
            mem_ctr[r_s1.col] <= {r_s1.dir, r_s1.pix};
        end
    end

    // window shift and center latch
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_win_c1[k] <= '0;
                r_win_c2[k] <= '0;
            end
            r_hold <= '0;
        end else if (r_s1_valid) begin
            for (int k = 0; k < 3; k++) begin
                r_win_c1[k] <= r_win_c2[k];
            end
            r_win_c2[0] <= r_older_rd;
            r_win_c2[1] <= r_prev_rd;
            r_win_c2[2] <= r_s1.mag;
            r_hold      <= r_ctr_rd;
        end
    end

    // peak decision for the center of the shifted window
    always_comb begin
        c_dir = r_hold[PIX_BITS +: DIR_BITS];
        c_pix = r_hold[PIX_BITS-1:0];
        c_mag = r_win_c2[1];
        keep  = 1'b0;
        if (r_s1.col >= ADDR_BITS'(2) && r_s1.row >= HEIGHT_BITS'(2)) begin
            unique case (c_dir)
                DIR_0:   keep = is_peak(c_mag, r_win_c1[1], r_prev_rd);
                DIR_45:  keep = is_peak(c_mag, r_older_rd, r_win_c1[2]);
                DIR_90:  keep = is_peak(c_mag, r_win_c2[0], r_win_c2[2]);
                DIR_135: keep = is_peak(c_mag, r_win_c1[0], r_s1.mag);
                default: keep = 1'b0;
            endcase
        end
        res_valid = r_s1_valid && (r_s1.col != '0) && (r_s1.row != '0);
        res_col   = r_s1.col - 1'b1;
        res_row   = r_s1.row - 1'b1;
        res_word  = {keep, (keep ? c_pix : {PIX_BITS{1'b0}}), res_row, res_col};
    end

    // output queue storage
    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_q[r_wr_ptr] <= res_word;
        end
    end

    // output queue pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_q_cnt  <= '0;
        end else begin
            if (res_valid) begin
                r_wr_ptr <= (r_wr_ptr == 2'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (out_pop) begin
                r_rd_ptr <= (r_rd_ptr == 2'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_q_cnt <= r_q_cnt + 2'(res_valid) - 2'(out_pop);
        end
    end

    // result port
    assign head       = r_q[r_rd_ptr];
    assign o_m_tvalid = (r_q_cnt != '0);
    assign o_m_tdata  = {{(OUT_DATA_BITS - RES_BITS + 1){1'b0}}, head[RES_BITS-2:0]};
    assign o_m_tuser  = head[RES_BITS-1];

endmodule

### hdl/dnms_checker.sv
// port-level checks for the directional non-max suppression block
module dnms_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_s_tvalid,
    input logic                                o_s_tready,
    input logic [dnms_pkg::IN_DATA_BITS-1:0]   i_s_tdata,
    input logic                                o_m_tvalid,
    input logic                                i_m_tready,
    input logic [dnms_pkg::OUT_DATA_BITS-1:0]  o_m_tdata,
    input logic                                o_m_tuser
);
    import dnms_pkg::*;

    // a waiting pixel request stays offered and unchanged
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && !o_s_tready |=> i_s_tvalid && $stable(i_s_tdata))
        else $error("pixel request changed while waiting");

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result dropped while stalled");

    // nothing is offered right after reset
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_m_tvalid)
        else $error("result offered right after reset");

    // a suppressed pixel is black
    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata[29:22] == 8'd0)
        else $error("suppressed pixel not black");

    // border pixels are never kept
    a_border: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> (o_m_tdata[9:0] != 10'd0) && (o_m_tdata[21:10] != 12'd0))
        else $error("border pixel kept");

endmodule

bind directional_non_max_suppression dnms_checker u_dnms_checker (.*);

### sim/tb.sv
// self-checking testbench for the directional non-max suppression block
`timescale 1ns / 1ps

module tb;

    // one decided center pixel as it should leave the block
    typedef struct {
        bit [9:0]  col;
        bit [11:0] row;
        bit [7:0]  pix;
        bit        kept;
    } t_decision;

    // predicts the decision for every accepted pixel and checks results in order
    class nms_scoreboard;
        bit [15:0]     line_prev  [dnms_pkg::MAX_WIDTH];
        bit [15:0]     line_older [dnms_pkg::MAX_WIDTH];
        bit [10:0]     center_row [dnms_pkg::MAX_WIDTH];
        bit [15:0]     win [9];
        bit [10:0]     center_hold;
        int unsigned   col_pos;
        int unsigned   row_pos;
        bit [10:0]     width_reg;
        bit [11:0]     height_reg;
        t_decision     pending_decisions[$];
        int            errors;
        int            decisions;
        int            kept_total;
        int            pixels;

        function new();
            width_reg  = dnms_pkg::WIDTH_RESET;
            height_reg = dnms_pkg::HEIGHT_RESET;
        endfunction

        function void write_reg(logic idx, logic [11:0] value);
            if (idx == dnms_pkg::CFG_IMAGE_WIDTH) begin
                width_reg = value[10:0];
            end else begin
                height_reg = value;
            end
        endfunction

        // center not below either neighbour and not tied with both
        function bit local_max(bit [15:0] c, bit [15:0] a, bit [15:0] b);
            return (c >= a && c >= b) && !(c == a && c == b);
        endfunction

        function void note_pixel(bit [15:0] mag, bit [2:0] dir, bit [7:0] pix);
            int unsigned   w;
            int unsigned   h;
            int unsigned   c;
            int unsigned   r;
            int            k;
            bit [10:0]     centre;
            bit            keep;
            t_decision     res;
            w = width_reg;
            if (w < 3) w = 3;
            if (w > dnms_pkg::MAX_WIDTH) w = dnms_pkg::MAX_WIDTH;
            h = height_reg;
            if (h < 3) h = 3;
            // a frame shrunk under the current position wraps first
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos++;
            end
            if (row_pos >= h) row_pos = 0;
            c = col_pos;
            r = row_pos;
            pixels++;
            // slide the window and rotate the line stores
            for (k = 0; k < 3; k++) begin
                win[k*3]   = win[k*3+1];
                win[k*3+1] = win[k*3+2];
            end
            win[2] = line_older[c];
            win[5] = line_prev[c];
            win[8] = mag;
            line_older[c] = line_prev[c];
            line_prev[c]  = mag;
            centre        = center_hold;
            center_hold   = center_row[c];
            center_row[c] = {dir, pix};
            // decide the pixel up and left of this one
            if (c >= 1 && r >= 1) begin
                keep = 1'b0;
                if (c >= 2 && r >= 2) begin
                    case (centre[10:8])
                        dnms_pkg::DIR_0: begin
                            keep = local_max(win[4], win[3], win[5]);
                        end
                        dnms_pkg::DIR_45: begin
                            keep = local_max(win[4], win[2], win[6]);
                        end
                        dnms_pkg::DIR_90: begin
                            keep = local_max(win[4], win[1], win[7]);
                        end
                        dnms_pkg::DIR_135: begin
                            keep = local_max(win[4], win[0], win[8]);
                        end
                        default: begin
                            keep = 1'b0;
                        end
                    endcase
                end
                res.col  = 10'(c - 1);
                res.row  = 12'(r - 1);
                res.pix  = keep ? centre[7:0] : 8'd0;
                res.kept = keep;
                pending_decisions.push_back(res);
            end
            // advance the raster position
            col_pos = c + 1;
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos = r + 1;
                if (row_pos >= h) row_pos = 0;
            end
        endfunction

        function void match_field(string name, logic [11:0] want, logic [11:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [31:0] data, logic user);
            t_decision want;
            if (pending_decisions.size() == 0) begin
                $display("%0t: expected no result, got column %0d row %0d",
                         $time, data[9:0], data[21:10]);
                errors++;
                return;
            end
            want = pending_decisions.pop_front();
            decisions++;
            if (want.kept) kept_total++;
            match_field("column", 12'(want.col), 12'(data[9:0]));
            match_field("row", want.row, data[21:10]);
            match_field("pixel_out", 12'(want.pix), 12'(data[29:22]));
            match_field("kept", 12'(want.kept), 12'(user));
        endfunction
    endclass

    localparam int SINK_HOLD   = 150;
    localparam int QUIET_LIMIT = 2000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = dnms_pkg::CFG_IMAGE_WIDTH;
    logic [11:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;

    nms_scoreboard sb;
    bit            calm = 1'b0;
    int            hold_asked = 0;
    int            hold_seen = 0;
    int            hold_left = 0;

    // hand-made 5x5 frame: every direction, unknown codes, extremes and ties
    int unsigned frame_mag [25] = '{
        0,     65535, 0,     65535, 0,
        100,   200,   100,   300,   65535,
        200,   200,   200,   65535, 65534,
        0,     300,   200,   100,   65535,
        65535, 0,     65535, 0,     0
    };
    int unsigned frame_dir [25] = '{
        5, 6, 7, 4, 0,
        1, 0, 1, 2, 3,
        2, 3, 0, 2, 1,
        4, 4, 7, 1, 0,
        6, 5, 3, 2, 1
    };
    int unsigned frame_pix [25] = '{
        0,   17,  34,  51,  68,
        85,  255, 119, 136, 153,
        170, 0,   204, 221, 238,
        1,   2,   4,   8,   16,
        32,  64,  128, 254, 127
    };

    directional_non_max_suppression DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser)
    );

    // 10 ns clock
    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // result side: check each taken result, then pick next cycle's ready
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            sb.check_result(m_tdata, m_tuser);
        end
        if (hold_seen != hold_asked) begin
            hold_seen = hold_asked;
            hold_left = SINK_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (calm) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= 21);
        end
    end

    // watchdog: too long without any request moving on either side
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
        $display("tb: done, errors");
        $finish;
    end

    task automatic write_reg(logic idx, logic [11:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.write_reg(idx, value);
    endtask

    // offer one pixel, maybe after random idle cycles, and wait until it is taken
    task automatic send_pixel(bit [15:0] mag, bit [2:0] dir, bit [7:0] pix);
        if (!calm) begin
            while ($urandom_range(99) < 21) begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, pix, dir, mag};
        do @(posedge clk); while (!s_tready);
        sb.note_pixel(mag, dir, pix);
    endtask

    task automatic send_random_pixel();
        bit [15:0] mag;
        bit [2:0]  dir;
        // small ranges give plenty of ties along the direction
        case ($urandom_range(9))
            0:       mag = 16'd0;
            1:       mag = 16'hFFFF;
            2, 3, 4: mag = 16'($urandom_range(3));
            5:       mag = 16'hFFFF - 16'($urandom_range(2));
            default: mag = 16'($urandom);
        endcase
        if ($urandom_range(99) < 85) begin
            dir = 3'($urandom_range(3));
        end else begin
            dir = 3'($urandom_range(7, 4));
        end
        send_pixel(mag, dir, 8'($urandom_range(255)));
    endtask

    task automatic feed(int count);
        repeat (count) send_random_pixel();
    endtask

    // run on to the first pixel of the next frame
    task automatic feed_to_frame_start();
        while (sb.col_pos != 0 || sb.row_pos != 0) send_random_pixel();
    endtask

    // stop sending until every awaited result is out and the pipe is empty
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_decisions.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    initial begin
        int i;
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed 5x5 frame
        write_reg(dnms_pkg::CFG_IMAGE_WIDTH, 12'd5);
        write_reg(dnms_pkg::CFG_IMAGE_HEIGHT, 12'd5);
        for (i = 0; i < 25; i++) begin
            send_pixel(16'(frame_mag[i]), 3'(frame_dir[i]), 8'(frame_pix[i]));
        end
        drain();

        // registers below range clamp to a 3x3 frame
        write_reg(dnms_pkg::CFG_IMAGE_WIDTH, 12'd0);
        write_reg(dnms_pkg::CFG_IMAGE_HEIGHT, 12'd0);
        feed(20);
        feed_to_frame_start();
        drain();

        // long stretch with no gaps on either side
        write_reg(dnms_pkg::CFG_IMAGE_WIDTH, 12'd7);
        write_reg(dnms_pkg::CFG_IMAGE_HEIGHT, 12'd6);
        calm = 1'b1;
        feed(50);
        calm = 1'b0;

        // sink holds off while pixels keep coming, block backs up
        hold_asked++;
        feed(40);
        drain();

        // frame shrunk in the middle of a frame
        write_reg(dnms_pkg::CFG_IMAGE_WIDTH, 12'd4);
        write_reg(dnms_pkg::CFG_IMAGE_HEIGHT, 12'd2);
        feed(20);
        feed_to_frame_start();
        drain();

        // widest frame: width above range clamps to the maximum
        write_reg(dnms_pkg::CFG_IMAGE_WIDTH, 12'd2047);
        write_reg(dnms_pkg::CFG_IMAGE_HEIGHT, 12'd4095);
        feed(dnms_pkg::MAX_WIDTH + 20);
        drain();

        // narrow it mid row, position wraps to the next row
        write_reg(dnms_pkg::CFG_IMAGE_WIDTH, 12'd16);
        write_reg(dnms_pkg::CFG_IMAGE_HEIGHT, 12'd3);
        feed_to_frame_start();
        drain();

        // tall narrow frame, then cut the height under the current row
        write_reg(dnms_pkg::CFG_IMAGE_WIDTH, 12'd3);
        write_reg(dnms_pkg::CFG_IMAGE_HEIGHT, 12'd4095);
        feed(36);
        drain();
        write_reg(dnms_pkg::CFG_IMAGE_HEIGHT, 12'd10);
        feed(20);
        feed_to_frame_start();
        drain();

        // closing random frames
        write_reg(dnms_pkg::CFG_IMAGE_WIDTH, 12'd11);
        write_reg(dnms_pkg::CFG_IMAGE_HEIGHT, 12'd7);
        feed(40);
        drain();

        $display("tb: %0d pixels sent, %0d decisions checked, %0d of them kept",
                 sb.pixels, sb.decisions, sb.kept_total);
        $display("tb: frames from 3x3 up to 1024 wide and 4095 high, mid-frame shrinks");
        if (sb.errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
